// ----- src/bdke_pkg.sv -----
// Shared types, constants and the key map of the debounced keypad.
package bdke_pkg;

	localparam int NUM_BUTTONS = 5;
	localparam int TIME_BITS = 32;
	localparam int LEVEL_BITS = 5;
	localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int DEBOUNCE_W = 16;
	localparam int MODE_W = 2;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(50);

	localparam logic [1:0] LEVEL_UNKNOWN = 2'd2;

	localparam logic [MODE_W-1:0] MODE_NAV = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EDIT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SLIDER = 2'd2;

	localparam logic REG_CONTROL_MODE = 1'b0;
	localparam logic REG_DEBOUNCE = 1'b1;

	typedef enum logic [2:0] {
		KEY_NONE  = 3'd0,
		KEY_UP    = 3'd1,
		KEY_DOWN  = 3'd2,
		KEY_LEFT  = 3'd3,
		KEY_RIGHT = 3'd4,
		KEY_NEXT  = 3'd5,
		KEY_PREV  = 3'd6,
		KEY_ENTER = 3'd7
	} key_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] button_levels;
		logic [31:0]           now_ms;
	} poll_word_t;

	typedef struct packed {
		logic [2:0] key_code;
		logic       key_pressed;
		logic       key_valid;
	} result_word_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] index;
	} press_t;

	function automatic logic mode_known(input logic [MODE_W-1:0] mode);
		return (mode == MODE_NAV) || (mode == MODE_EDIT) || (mode == MODE_SLIDER);
	endfunction

	function automatic key_t key_map(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx);
		key_t k;
		k = KEY_NONE;
		case (idx)
			IDX_W'(0): begin
				k = (mode == MODE_EDIT) ? KEY_UP : KEY_PREV;
			end
			IDX_W'(1): begin
				k = (mode == MODE_EDIT) ? KEY_DOWN : KEY_NEXT;
			end
			IDX_W'(2): begin
				k = KEY_LEFT;
			end
			IDX_W'(3): begin
				k = (mode == MODE_NAV) ? KEY_ENTER : KEY_RIGHT;
			end
			IDX_W'(4): begin
				k = KEY_ENTER;
			end
			default: begin
				k = KEY_NONE;
			end
		endcase
		return k;
	endfunction

endpackage

// ----- src/bdke_scan.sv -----
// Per-button debounce state and the priority scan for the first accepted press.
module bdke_scan (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic [bdke_pkg::LEVEL_BITS-1:0]      levels,
	input  logic [31:0]                          now_ms,
	input  logic [bdke_pkg::DEBOUNCE_W-1:0]      debounce,
	output bdke_pkg::press_t                     press
);

	logic [1:0]                     level_q [bdke_pkg::NUM_BUTTONS];
	logic [bdke_pkg::TIME_BITS-1:0] time_q  [bdke_pkg::NUM_BUTTONS];

	logic [bdke_pkg::NUM_BUTTONS-1:0] lvl;
	logic [bdke_pkg::NUM_BUTTONS-1:0] cond;
	logic [bdke_pkg::NUM_BUTTONS-1:0] upd;
	logic [bdke_pkg::TIME_BITS-1:0]   now_t;
	logic [bdke_pkg::TIME_BITS-1:0]   elapsed [bdke_pkg::NUM_BUTTONS];

	assign lvl = bdke_pkg::NUM_BUTTONS'(levels);
	assign now_t = bdke_pkg::TIME_BITS'(now_ms);

	always_comb begin
		for (int i = 0; i < bdke_pkg::NUM_BUTTONS; i++) begin
			elapsed[i] = now_t - time_q[i];
			cond[i] = ({1'b0, lvl[i]} != level_q[i]) &&
				(elapsed[i] > bdke_pkg::TIME_BITS'(debounce));
		end
	end

	// Buttons after the first accepted press keep their state for this poll.
	always_comb begin
		logic blocked;
		blocked = 1'b0;
		press = '0;
		for (int i = 0; i < bdke_pkg::NUM_BUTTONS; i++) begin
			upd[i] = cond[i] & ~blocked;
			if (cond[i] && lvl[i] && !blocked) begin
				press.found = 1'b1;
				press.index = bdke_pkg::IDX_W'(i);
			end
			blocked = blocked | (cond[i] & lvl[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bdke_pkg::NUM_BUTTONS; i++) begin
				level_q[i] <= bdke_pkg::LEVEL_UNKNOWN;
				time_q[i] <= '0;
			end
		end else if (adv) begin
			for (int i = 0; i < bdke_pkg::NUM_BUTTONS; i++) begin
				if (upd[i]) begin
					level_q[i] <= {1'b0, lvl[i]};
					time_q[i] <= now_t;
				end
			end
		end
	end

endmodule

// ----- src/bdke_event.sv -----
// Pending key state, key map lookup and the result register.
module bdke_event (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              result_ready,
	input  logic [bdke_pkg::MODE_W-1:0]       mode,
	input  bdke_pkg::press_t                  press,
	output logic                              slot_free,
	output logic                              result_valid,
	output bdke_pkg::result_word_t            result
);

	bdke_pkg::key_t         pend_key_q;
	logic                   pend_pressed_q;
	logic                   valid_q;
	bdke_pkg::result_word_t result_q;

	bdke_pkg::key_t         key_now;
	logic                   pressed_now;
	logic                   report;
	bdke_pkg::result_word_t word_now;

	always_comb begin
		key_now = pend_key_q;
		pressed_now = pend_pressed_q;
		if (press.found) begin
			pressed_now = 1'b1;
			if (bdke_pkg::mode_known(mode)) begin
				key_now = bdke_pkg::key_map(mode, press.index);
			end
		end
		report = (key_now != bdke_pkg::KEY_NONE);
		word_now = '0;
		if (report) begin
			word_now.key_code = key_now;
			word_now.key_pressed = pressed_now;
			word_now.key_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_key_q <= bdke_pkg::KEY_NONE;
			pend_pressed_q <= 1'b0;
		end else if (adv) begin
			if (report && !pressed_now) begin
				pend_key_q <= bdke_pkg::KEY_NONE;
			end else begin
				pend_key_q <= key_now;
			end
			pend_pressed_q <= report ? 1'b0 : pressed_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= word_now;
		end
	end

	assign slot_free = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign result = result_q;

endmodule

// ----- src/button_debounce_keymap_events_core.sv -----
// Debounced five-button keypad turning polls into key events.
// Accepted polls pass the input register, then the result register.
// Throughput: one poll word per cycle while the result slot is free or being read.
// Reset clears the input and result valid flags, sets every button level to unknown,
// change times to zero, no pending key, navigate mode and a 50 ms debounce.
module button_debounce_keymap_events_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              poll_valid,
	output logic                              poll_ready,
	input  bdke_pkg::poll_word_t              poll,
	output logic                              result_valid,
	input  logic                              result_ready,
	output bdke_pkg::result_word_t            result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bdke_pkg::ADDR_W-1:0]       paddr,
	input  logic [bdke_pkg::DATA_W-1:0]       pwdata,
	output logic [bdke_pkg::DATA_W-1:0]       prdata,
	output logic                              pready
);

	logic [bdke_pkg::MODE_W-1:0]     mode_q;
	logic [bdke_pkg::DEBOUNCE_W-1:0] debounce_q;
	logic                            valid_s1;
	bdke_pkg::poll_word_t            poll_s1;
	logic                            slot_free;
	logic                            adv;
	logic                            wr_en;
	bdke_pkg::press_t                press;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bdke_pkg::MODE_NAV;
			debounce_q <= bdke_pkg::DEBOUNCE_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				bdke_pkg::REG_CONTROL_MODE: mode_q <= pwdata[bdke_pkg::MODE_W-1:0];
				bdke_pkg::REG_DEBOUNCE: debounce_q <= pwdata[bdke_pkg::DEBOUNCE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			bdke_pkg::REG_CONTROL_MODE: prdata = bdke_pkg::DATA_W'(mode_q);
			bdke_pkg::REG_DEBOUNCE: prdata = bdke_pkg::DATA_W'(debounce_q);
			default: prdata = '0;
		endcase
	end

	assign adv = valid_s1 && slot_free;
	assign poll_ready = !valid_s1 || slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll_ready) begin
			valid_s1 <= poll_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_valid && poll_ready) begin
			poll_s1 <= poll;
		end
	end

	bdke_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.levels   (poll_s1.button_levels),
		.now_ms   (poll_s1.now_ms),
		.debounce (debounce_q),
		.press    (press)
	);

	bdke_event u_event (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.result_ready (result_ready),
		.mode         (mode_q),
		.press        (press),
		.slot_free    (slot_free),
		.result_valid (result_valid),
		.result       (result)
	);

	a_pressed_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.key_valid ||
			(!result.key_pressed && result.key_code == bdke_pkg::KEY_NONE)))
		else $error("result word reports a key without key_valid");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> poll_ready)
		else $error("poll stalled while the result register is empty");

	a_word_follows_poll: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && slot_free) |=> result_valid)
		else $error("advanced poll did not produce a result word");

endmodule
